>>> sv/pabp_pkg.sv
// ----------------------------------------------------------------------------
// Particle advection package
// Shared types and constants for the bilinear periodic advection pipeline.
// ----------------------------------------------------------------------------
package pabp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int POS_W       = 24;
   localparam int CELL_W      = 8;
   localparam int VEL_W       = 16;
   localparam int SCALE_W     = 16;
   localparam int BANK_ADDR_W = 2 * (CELL_W - 1);
   localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;
   localparam int BANK_DATA_W = 2 * VEL_W + 1;

   localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 16'd256;
   localparam logic [POS_W-1:0]   HALF_CELL        = 24'h008000;

   localparam logic [1:0] ADDR_STEP_SCALE = 2'd0;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [CELL_W-1:0]        cell_col;
      logic [CELL_W-1:0]        cell_row;
      logic signed [VEL_W-1:0]  cell_vel_u;
      logic signed [VEL_W-1:0]  cell_vel_v;
      logic                     cell_blocked;
      logic [POS_W-1:0]         pos_x;
      logic [POS_W-1:0]         pos_y;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] new_x;
      logic [POS_W-1:0] new_y;
      logic             blocked;
   } rsp_type;

endpackage

>>> sv/particle_advect_bilinear_periodic.sv
// ----------------------------------------------------------------------------
// Particle advection with bilinear velocity interpolation
// Moves particles through a stored velocity grid with periodic wrap.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high; busy is always low, so an item
// may be offered in every cycle. A load item writes one cell of the velocity
// grid and gives no result. A move item gives one result on rsp_data, shown
// for one cycle with rsp_valid high, after passing the stage 1 to 4 registers
// into the output register. Throughput is one item per clock cycle. The grid is
// split into four banks by the parity of column and row, so the four
// neighbouring cells of a particle are read in the same cycle; the pipeline
// has three multiply stages (two interpolation steps and the step scaling).
// The receiver cannot stall the result channel.
// step_scale lives at byte address 0 of the APB port and resets to 256.
// Reset clears the pipeline valid bits and the register; the grid is not
// cleared and every cell must be loaded before a particle samples it.
// ----------------------------------------------------------------------------
module particle_advect_bilinear_periodic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pabp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output pabp_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [1:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import pabp_pkg::*;

   localparam int ROW_W  = 2 * VEL_W + 2;
   localparam int ALL_W  = ROW_W + FRAC_BITS + 2;
   localparam int VEL_IW = ALL_W - FRAC_BITS;
   localparam int PROD_W = VEL_IW + SCALE_W + 1;
   // The product carries 12 extra velocity fraction bits and 8 scale
   // fraction bits above the position format.
   localparam int DISP_LSB = 12 + 8;

   // Configuration register.
   logic [SCALE_W-1:0] step_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_scale_ff <= STEP_SCALE_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_STEP_SCALE)) begin
         step_scale_ff <= pwdata[SCALE_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = {{(32-SCALE_W){1'b0}}, step_scale_ff};
   assign busy   = 1'b0;

   // Stage 0: bank addressing.
   logic             take;
   logic             is_move;
   logic [POS_W-1:0] sx;
   logic [POS_W-1:0] sy;
   logic [CELL_W-1:0] c0, c1, r0, r1;
   logic [BANK_ADDR_W-1:0] rd_addr [4];
   logic [BANK_ADDR_W-1:0] wr_addr;
   logic [BANK_DATA_W-1:0] wr_data;
   logic [BANK_DATA_W-1:0] rd_data [4];
   logic [1:0]             wr_bank;

   assign take    = start;
   assign is_move = (req_data.op == OP_MOVE);
   assign sx      = req_data.pos_x - HALF_CELL;
   assign sy      = req_data.pos_y - HALF_CELL;
   assign c0      = sx[POS_W-1:FRAC_BITS];
   assign r0      = sy[POS_W-1:FRAC_BITS];
   assign c1      = c0 + 8'd1;
   assign r1      = r0 + 8'd1;
   assign wr_addr = {req_data.cell_row[CELL_W-1:1], req_data.cell_col[CELL_W-1:1]};
   assign wr_data = {req_data.cell_vel_u, req_data.cell_vel_v, req_data.cell_blocked};
   assign wr_bank = {req_data.cell_row[0], req_data.cell_col[0]};

   // Bank index is {row parity, column parity}.
   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [CELL_W-1:0] col_sel;
      logic [CELL_W-1:0] row_sel;

      assign col_sel    = (c0[0] == g[0]) ? c0 : c1;
      assign row_sel    = (r0[0] == g[1]) ? r0 : r1;
      assign rd_addr[g] = {row_sel[CELL_W-1:1], col_sel[CELL_W-1:1]};

      pabp_ram #(
         .WIDTH(BANK_DATA_W),
         .DEPTH(BANK_DEPTH)
      ) u_ram (
         .clock  (clock),
         .wr_en  (take && !is_move && (wr_bank == 2'(g))),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_addr(rd_addr[g]),
         .rd_data(rd_data[g])
      );
   end

   logic                 s1_valid_ff;
   logic [POS_W-1:0]     s1_x_ff, s1_y_ff;
   logic [FRAC_BITS-1:0] s1_t_ff, s1_u_ff;
   logic                 s1_cp_ff, s1_rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take && is_move;
      end
      s1_x_ff  <= req_data.pos_x;
      s1_y_ff  <= req_data.pos_y;
      s1_t_ff  <= sx[FRAC_BITS-1:0];
      s1_u_ff  <= sy[FRAC_BITS-1:0];
      s1_cp_ff <= c0[0];
      s1_rp_ff <= r0[0];
   end

   // Stage 1: corner selection and the horizontal step.
   logic [1:0] ia, ib, ic, id, io;
   logic signed [VEL_W-1:0] ua, ub, uc, ud, va, vb, vc, vd;
   logic signed [FRAC_BITS:0] t_s;
   logic signed [ROW_W-1:0] u_row0_in, u_row1_in, v_row0_in, v_row1_in;
   logic        obs_sel;

   assign ia = {s1_rp_ff, s1_cp_ff};
   assign ib = {s1_rp_ff, ~s1_cp_ff};
   assign ic = {~s1_rp_ff, s1_cp_ff};
   assign id = {~s1_rp_ff, ~s1_cp_ff};
   // The particle's own cell is the left one when its fraction is at least
   // one half, otherwise the right one; likewise for rows.
   assign io = {s1_y_ff[FRAC_BITS-1] ? s1_rp_ff : ~s1_rp_ff,
                s1_x_ff[FRAC_BITS-1] ? s1_cp_ff : ~s1_cp_ff};

   assign ua = rd_data[ia][BANK_DATA_W-1 -: VEL_W];
   assign ub = rd_data[ib][BANK_DATA_W-1 -: VEL_W];
   assign uc = rd_data[ic][BANK_DATA_W-1 -: VEL_W];
   assign ud = rd_data[id][BANK_DATA_W-1 -: VEL_W];
   assign va = rd_data[ia][VEL_W:1];
   assign vb = rd_data[ib][VEL_W:1];
   assign vc = rd_data[ic][VEL_W:1];
   assign vd = rd_data[id][VEL_W:1];
   assign obs_sel = rd_data[io][0];
   assign t_s = {1'b0, s1_t_ff};

   // a*(1-t) + b*t is written as a*ONE + (b-a)*t.
   assign u_row0_in = (ROW_W'(ua) <<< FRAC_BITS)
                    + ROW_W'((ROW_W'(ub) - ROW_W'(ua)) * ROW_W'(t_s));
   assign u_row1_in = (ROW_W'(uc) <<< FRAC_BITS)
                    + ROW_W'((ROW_W'(ud) - ROW_W'(uc)) * ROW_W'(t_s));
   assign v_row0_in = (ROW_W'(va) <<< FRAC_BITS)
                    + ROW_W'((ROW_W'(vb) - ROW_W'(va)) * ROW_W'(t_s));
   assign v_row1_in = (ROW_W'(vc) <<< FRAC_BITS)
                    + ROW_W'((ROW_W'(vd) - ROW_W'(vc)) * ROW_W'(t_s));

   logic                    s2_valid_ff;
   logic [POS_W-1:0]        s2_x_ff, s2_y_ff;
   logic [FRAC_BITS-1:0]    s2_u_ff;
   logic                    s2_blk_ff;
   logic signed [ROW_W-1:0] u_row0_ff, u_row1_ff, v_row0_ff, v_row1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_x_ff   <= s1_x_ff;
      s2_y_ff   <= s1_y_ff;
      s2_u_ff   <= s1_u_ff;
      s2_blk_ff <= obs_sel;
      u_row0_ff <= u_row0_in;
      u_row1_ff <= u_row1_in;
      v_row0_ff <= v_row0_in;
      v_row1_ff <= v_row1_in;
   end

   // Stage 2: vertical step and rounding toward minus infinity.
   logic signed [ALL_W-1:0]  u_all, v_all;
   logic signed [FRAC_BITS:0] u_s;

   assign u_s   = {1'b0, s2_u_ff};
   assign u_all = (ALL_W'(u_row0_ff) <<< FRAC_BITS)
                + ALL_W'((ALL_W'(u_row1_ff) - ALL_W'(u_row0_ff)) * ALL_W'(u_s));
   assign v_all = (ALL_W'(v_row0_ff) <<< FRAC_BITS)
                + ALL_W'((ALL_W'(v_row1_ff) - ALL_W'(v_row0_ff)) * ALL_W'(u_s));

   logic                     s3_valid_ff;
   logic [POS_W-1:0]         s3_x_ff, s3_y_ff;
   logic                     s3_blk_ff;
   logic signed [VEL_IW-1:0] vx_ff, vy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_x_ff   <= s2_x_ff;
      s3_y_ff   <= s2_y_ff;
      s3_blk_ff <= s2_blk_ff;
      vx_ff     <= u_all[ALL_W-1:FRAC_BITS];
      vy_ff     <= v_all[ALL_W-1:FRAC_BITS];
   end

   // Stage 3: scale by the time step. Only the low position bits of the
   // displacement survive the wrap, so the rest is dropped here.
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic signed [SCALE_W:0]  scale_s;

   assign scale_s = {1'b0, step_scale_ff};
   assign prod_x  = PROD_W'(vx_ff) * PROD_W'(scale_s);
   assign prod_y  = PROD_W'(vy_ff) * PROD_W'(scale_s);

   logic             s4_valid_ff;
   logic [POS_W-1:0] s4_x_ff, s4_y_ff;
   logic             s4_blk_ff;
   logic [POS_W-1:0] dx_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_x_ff   <= s3_x_ff;
      s4_y_ff   <= s3_y_ff;
      s4_blk_ff <= s3_blk_ff;
      dx_ff     <= prod_x[DISP_LSB +: POS_W];
      dy_ff     <= prod_y[DISP_LSB +: POS_W];
   end

   // Stage 4: add and wrap, or keep the position when the cell is blocked; the grid span equals the position range.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.blocked = s4_blk_ff;
      if (s4_blk_ff) begin
         rsp_data_in.new_x = s4_x_ff;
         rsp_data_in.new_y = s4_y_ff;
      end else begin
         rsp_data_in.new_x = s4_x_ff + dx_ff;
         rsp_data_in.new_y = s4_y_ff + dy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s4_valid_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/pabp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pabp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
